// ===== rtl/pkst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_pkg
// Shared types and constants for the position-keyed state table.
// ----------------------------------------------------------------------------
package pkst_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    ACT_ADD        = 3'd0,
    ACT_FIND_ANY   = 3'd1,
    ACT_FIND_TYPE  = 3'd2,
    ACT_MARK_POS   = 3'd3,
    ACT_MARK_TYPE  = 3'd4,
    ACT_COMPACT    = 3'd5
  } action_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic [3:0]  kind;
    logic [31:0] word;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/pkst_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pkst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/position_keyed_state_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// position_keyed_state_table
// Ordered table of position-keyed entries and their removal marks in one RAM.
// Add registers its result strobe on accept; the next beat may start in the
// cycle after accept.
// Find, mark and compact walk the table one RAM read per cycle and hold busy
// until the result strobe (a find stops on first hit).
// Synchronous reset empties the table; each added entry starts unmarked.
// ----------------------------------------------------------------------------
module position_keyed_state_table
  import pkst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  pos_x,
  input  wire logic [7:0]  pos_y,
  input  wire logic [7:0]  pos_z,
  input  wire logic [3:0]  kind,
  input  wire logic [31:0] payload,
  output logic             done,
  output logic             found,
  output logic [5:0]       slot,
  output logic [31:0]      data_out,
  output logic             status,
  output logic [6:0]       occupancy
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  typedef struct packed {
    logic   mark;
    entry_t ent;
  } row_t;

  state_t                   state;
  action_t                  act;
  action_t                  act_in;
  logic [7:0]               key_x;
  logic [7:0]               key_y;
  logic [7:0]               key_z;
  logic [3:0]               key_kind;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         rd_idx;
  logic [CNT_W-1:0]         wr_ptr;
  logic                     rd_vld;
  logic [IDX_W-1:0]         rd_pos;

  logic [$bits(row_t)-1:0]  rd_data;
  row_t                     rd_row;
  row_t                     wr_row;
  entry_t                   rd_entry;
  logic                     we;
  logic [IDX_W-1:0]         wr_addr;
  logic [IDX_W-1:0]         rd_addr;

  logic                     accept;
  logic                     can_add;
  logic                     issue;
  logic                     typed;
  logic                     is_find;
  logic                     is_mark;
  logic                     hit;
  logic                     find_hit;
  logic                     mark_wr;
  logic                     keep;
  logic                     scan_end;

  pkst_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign act_in   = action_t'(action);
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign can_add  = (count < CNT_W'(TABLE_ENTRIES));
  assign issue    = (state == ST_SCAN) && (rd_idx < count);
  assign rd_addr  = rd_idx[IDX_W-1:0];
  assign rd_row   = row_t'(rd_data);
  assign rd_entry = rd_row.ent;

  assign typed   = (act == ACT_FIND_TYPE) || (act == ACT_MARK_TYPE);
  assign is_find = (act == ACT_FIND_ANY) || (act == ACT_FIND_TYPE);
  assign is_mark = (act == ACT_MARK_POS) || (act == ACT_MARK_TYPE);

  assign hit = rd_vld && (rd_entry.x == key_x) && (rd_entry.y == key_y) &&
               (rd_entry.z == key_z) && (!typed || (rd_entry.kind == key_kind));

  assign find_hit = (state == ST_SCAN) && is_find && hit;
  assign mark_wr  = (state == ST_SCAN) && is_mark && hit;
  assign keep     = (state == ST_SCAN) && rd_vld && (act == ACT_COMPACT) && !rd_row.mark;
  assign scan_end = (state == ST_SCAN) && ((!issue && !rd_vld) || find_hit);

  always_comb begin
    we      = keep || mark_wr || (accept && (act_in == ACT_ADD) && can_add);
    wr_addr = count[IDX_W-1:0];
    wr_row  = rd_row;
    if (keep) begin
      wr_addr = wr_ptr[IDX_W-1:0];
    end else if (mark_wr) begin
      wr_addr     = rd_pos;
      wr_row.mark = 1'b1;
    end else begin
      wr_row.mark     = 1'b0;
      wr_row.ent.x    = pos_x;
      wr_row.ent.y    = pos_y;
      wr_row.ent.z    = pos_z;
      wr_row.ent.kind = kind;
      wr_row.ent.word = payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_vld    <= 1'b0;
      done      <= 1'b0;
      found     <= 1'b0;
      status    <= 1'b0;
      slot      <= '0;
      data_out  <= '0;
      occupancy <= '0;
      act       <= ACT_ADD;
      rd_idx    <= '0;
      wr_ptr    <= '0;
    end else begin
      done   <= 1'b0;
      rd_vld <= issue && !scan_end;
      rd_pos <= rd_addr;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            found    <= 1'b0;
            status   <= 1'b0;
            slot     <= '0;
            data_out <= '0;
            case (act_in)
              ACT_ADD: begin
                done <= 1'b1;
                if (can_add) begin
                  count     <= count + 1'b1;
                  slot      <= 6'(count);
                  occupancy <= 7'(count + 1'b1);
                end else begin
                  status    <= 1'b1;
                  occupancy <= 7'(count);
                end
              end
              ACT_FIND_ANY, ACT_FIND_TYPE, ACT_MARK_POS, ACT_MARK_TYPE, ACT_COMPACT: begin
                state    <= ST_SCAN;
                act      <= act_in;
                key_x    <= pos_x;
                key_y    <= pos_y;
                key_z    <= pos_z;
                key_kind <= kind;
                rd_idx   <= '0;
                wr_ptr   <= '0;
              end
              default: begin
                done      <= 1'b1;
                occupancy <= 7'(count);
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (keep) begin
            wr_ptr <= wr_ptr + 1'b1;
          end
          if (scan_end) begin
            state <= ST_IDLE;
            done  <= 1'b1;
            if (find_hit) begin
              found    <= 1'b1;
              slot     <= 6'(rd_pos);
              data_out <= rd_entry.word;
            end
            if (act == ACT_COMPACT) begin
              count     <= wr_ptr;
              occupancy <= 7'(wr_ptr);
            end else begin
              occupancy <= 7'(count);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (wr_ptr <= rd_idx))
    else $error("compact write pointer ahead of read pointer");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx <= count))
    else $error("scan index beyond occupancy");

  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> !found)
    else $error("refused add reports a hit");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE) && !rd_vld)
    else $error("result strobe while scan still active");

endmodule

`default_nettype wire

// ===== tb/position_keyed_state_table_tb.sv =====
// ----------------------------------------------------------------------------
// position_keyed_state_table_tb
// Self-checking bench for the position-keyed state table. A scoreboard keeps
// its own copy of the entries, removal marks and count, predicts one result
// per accepted beat and compares each done strobe against the oldest
// prediction. A short directed run covers empty-table lookups, keys at
// the coordinate extremes, duplicate keys, finds that still see marked
// entries, the unused action codes and compaction. Random rounds then fill
// the table past full, churn it with mixed actions and purge it, using a
// small pool of keys so that finds and marks hit. Random gaps sit on the
// sender side, and the bench drains all pending results now and then.
// ----------------------------------------------------------------------------
module position_keyed_state_table_tb;
  import pkst_pkg::*;

  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_PURGE = 2;

  localparam int RANDOM_BEATS  = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic [31:0] data;
    logic        status;
    logic [6:0]  occ;
  } lookup_result_t;

  class state_table_scoreboard;
    entry_t         rows [TABLE_ENTRIES];
    bit             marked [TABLE_ENTRIES];
    int unsigned    held;
    lookup_result_t pending_q [$];
    int unsigned    errors;

    function new();
      held   = 0;
      errors = 0;
      foreach (marked[i]) marked[i] = 1'b0;
    endfunction

    function bit key_hit(entry_t e, entry_t q, bit typed);
      return e.x == q.x && e.y == q.y && e.z == q.z && (!typed || e.kind == q.kind);
    endfunction

    function void note_beat(logic [2:0] act, entry_t req);
      lookup_result_t r;
      int unsigned    w;
      r = '0;
      case (act)
        ACT_ADD: begin
          if (held >= TABLE_ENTRIES) begin
            r.status = 1'b1;
          end else begin
            rows[held]   = req;
            marked[held] = 1'b0;
            r.slot       = 6'(held);
            held++;
          end
        end
        ACT_FIND_ANY, ACT_FIND_TYPE: begin
          for (int i = 0; i < held; i++) begin
            if (key_hit(rows[i], req, act == ACT_FIND_TYPE)) begin
              r.found = 1'b1;
              r.slot  = 6'(i);
              r.data  = rows[i].word;
              break;
            end
          end
        end
        ACT_MARK_POS, ACT_MARK_TYPE: begin
          for (int i = 0; i < held; i++)
            if (key_hit(rows[i], req, act == ACT_MARK_TYPE)) marked[i] = 1'b1;
        end
        ACT_COMPACT: begin
          w = 0;
          for (int i = 0; i < held; i++) begin
            if (!marked[i]) begin
              rows[w]   = rows[i];
              marked[w] = 1'b0;
              w++;
            end
          end
          for (int i = w; i < TABLE_ENTRIES; i++) marked[i] = 1'b0;
          held = w;
        end
        default: ;
      endcase
      r.occ = 7'(held);
      pending_q.push_back(r);
    endfunction

    function void check_beat(lookup_result_t got);
      lookup_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: found=%0d slot=%0d data=%h status=%0d occ=%0d",
                   got.found, got.slot, got.data, got.status, got.occ);
        return;
      end
      want = pending_q.pop_front();
      if (got.found !== want.found || got.slot !== want.slot || got.data !== want.data ||
          got.status !== want.status || got.occ !== want.occ) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("result mismatch at %0t:", $realtime);
          $display("  expected found=%0d slot=%0d data=%h status=%0d occ=%0d",
                   want.found, want.slot, want.data, want.status, want.occ);
          $display("  actual   found=%0d slot=%0d data=%h status=%0d occ=%0d",
                   got.found, got.slot, got.data, got.status, got.occ);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic [2:0]  action    = ACT_ADD;
  logic [7:0]  pos_x     = '0;
  logic [7:0]  pos_y     = '0;
  logic [7:0]  pos_z     = '0;
  logic [3:0]  kind      = '0;
  logic [31:0] payload   = '0;
  logic        busy;
  logic        done;
  logic        found;
  logic [5:0]  slot;
  logic [31:0] data_out;
  logic        status;
  logic [6:0]  occupancy;

  state_table_scoreboard sb;
  logic [23:0]           key_pool [8];
  int                    beats_sent  = 0;
  int                    cycle_count = 0;

  position_keyed_state_table dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .kind      (kind),
    .payload   (payload),
    .done      (done),
    .found     (found),
    .slot      (slot),
    .data_out  (data_out),
    .status    (status),
    .occupancy (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_beat({found, slot, data_out, status, occupancy});
      if (start && !busy) sb.note_beat(action, {pos_x, pos_y, pos_z, kind, payload});
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input logic [2:0] act, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] z, input logic [3:0] k, input logic [31:0] p,
                           input bit may_idle);
    int gap;
    action  <= act;
    pos_x   <= x;
    pos_y   <= y;
    pos_z   <= z;
    kind    <= k;
    payload <= p;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    beats_sent++;
    gap = may_idle ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  task automatic send_random(input int mode, input bit may_idle);
    logic [2:0]  act;
    logic [23:0] key;
    logic [3:0]  k;
    int          r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: act = ACT_ADD;
      MODE_PURGE: begin
        if (r < 40)      act = ACT_MARK_POS;
        else if (r < 70) act = ACT_MARK_TYPE;
        else if (r < 85) act = ACT_COMPACT;
        else             act = ACT_FIND_ANY;
      end
      default: begin
        if (r < 35)      act = ACT_ADD;
        else if (r < 55) act = ACT_FIND_ANY;
        else if (r < 70) act = ACT_FIND_TYPE;
        else if (r < 80) act = ACT_MARK_POS;
        else if (r < 88) act = ACT_MARK_TYPE;
        else if (r < 97) act = ACT_COMPACT;
        else if (r < 98) act = ACT_SPARE_6;
        else             act = ACT_SPARE_7;
      end
    endcase
    key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)] : 24'($urandom);
    k   = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    send_beat(act, key[23:16], key[15:8], key[7:0], k, $urandom, may_idle);
  endtask

  initial begin
    int random_goal;
    int mode;
    int r;
    int round_len;
    bit steady;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    key_pool[0] = 24'h000000;
    key_pool[1] = 24'hffffff;
    for (int i = 2; i < 8; i++) key_pool[i] = 24'($urandom);

    send_beat(ACT_FIND_ANY,  8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_MARK_POS,  8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_COMPACT,   8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_ADD,       8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_ADD,       8'hff, 8'hff, 8'hff, 4'hf, 32'hffff_ffff, 1'b1);
    send_beat(ACT_ADD,       8'h00, 8'h00, 8'h00, 4'hf, 32'ha5a5_5a5a, 1'b1);
    send_beat(ACT_FIND_ANY,  8'h00, 8'h00, 8'h00, 4'h9, 32'h0000_0000, 1'b1);
    send_beat(ACT_FIND_TYPE, 8'h00, 8'h00, 8'h00, 4'hf, 32'h0000_0000, 1'b1);
    send_beat(ACT_FIND_TYPE, 8'h00, 8'h00, 8'h00, 4'h7, 32'h0000_0000, 1'b1);
    send_beat(ACT_FIND_ANY,  8'hff, 8'hff, 8'hff, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_MARK_TYPE, 8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_FIND_TYPE, 8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_SPARE_6,   8'hff, 8'hff, 8'hff, 4'hf, 32'hffff_ffff, 1'b1);
    send_beat(ACT_SPARE_7,   8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_COMPACT,   8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_FIND_ANY,  8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_MARK_POS,  8'hff, 8'hff, 8'hff, 4'h3, 32'h0000_0000, 1'b1);
    send_beat(ACT_FIND_ANY,  8'h01, 8'h02, 8'h03, 4'h0, 32'h0000_0000, 1'b1);
    send_beat(ACT_COMPACT,   8'h00, 8'h00, 8'h00, 4'h0, 32'h0000_0000, 1'b1);
    drain_results();

    random_goal = beats_sent + RANDOM_BEATS;
    repeat (TABLE_ENTRIES + 4) send_random(MODE_FILL, 1'b1);
    repeat (12) send_random(MODE_MIXED, 1'b0);
    drain_results();

    while (beats_sent < random_goal) begin
      r = $urandom_range(0, 99);
      if (r < 20)      mode = MODE_FILL;
      else if (r < 75) mode = MODE_MIXED;
      else             mode = MODE_PURGE;
      round_len = $urandom_range(15, 50);
      steady    = ($urandom_range(0, 3) == 0);
      repeat (round_len) send_random(mode, !steady);
      if ($urandom_range(0, 2) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pkst_pkg.sv
rtl/pkst_ram.sv
rtl/position_keyed_state_table.sv
tb/position_keyed_state_table_tb.sv
